>>> hdl/bppo_pkg.sv
// Shared types and constants for the pitch-balance PID outer loop.
// No dependencies; every other file in hdl/ refers to this package by scoped name.

package bppo_pkg;

    localparam int ANGLE_W  = 17;   // pitch angle and reference, 1/256 deg
    localparam int RATE_W   = 20;   // pitch rate, 1/256 deg/s
    localparam int ERR_W    = 18;   // angle minus reference
    localparam int GAIN_W   = 16;   // Q8.8 gains
    localparam int STEER_W  = 11;
    localparam int WHEEL_W  = 12;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;

    localparam int PROD_E_W = GAIN_W + ERR_W;      // gain * err
    localparam int PROD_R_W = GAIN_W + RATE_W;     // gain * rate
    localparam int PD_W     = PROD_R_W + 1;        // prop - deriv
    localparam int U_W      = PD_W + 2;            // full controller sum
    localparam int SUM_W    = 28;                  // integral plus increment
    localparam int WSUM_W   = 18;                  // base +/- steer before saturation

    localparam int INTEGRAL_LIMIT_DEF = 200;
    localparam int OUTPUT_LIMIT_DEF   = 200;

    localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST = 16'sd1536;

    localparam logic signed [WSUM_W-1:0] WHEEL_MAX = WSUM_W'(2047);
    localparam logic signed [WSUM_W-1:0] WHEEL_MIN = -WSUM_W'(2048);

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_REF    = 3'd1,
        REG_KP     = 3'd2,
        REG_KI     = 3'd3,
        REG_KD     = 3'd4,
        REG_STEER  = 3'd5
    } reg_idx_t;

    // one queued word: error and rate of an enabled tick
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [RATE_W-1:0] rate;
    } item_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  prop;
        logic signed [GAIN_W-1:0]  integ;
        logic signed [GAIN_W-1:0]  deriv;
        logic signed [STEER_W-1:0] steer;
    } gains_t;

endpackage

>>> hdl/bppo_front.sv
// Front end: takes pitch words, drops them while the loop is disabled, forms the error.
// Depends on bppo_pkg.

module bppo_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pitch_valid,
    output logic                                  pitch_ready,
    input  logic signed [bppo_pkg::ANGLE_W-1:0]   pitch_angle,
    input  logic signed [bppo_pkg::RATE_W-1:0]    pitch_rate,
    input  logic                                  loop_enable,
    input  logic signed [bppo_pkg::ANGLE_W-1:0]   pitch_reference,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output bppo_pkg::item_t                       push_item
);

    logic            valid_reg;
    logic            valid_next;
    bppo_pkg::item_t item_reg;
    bppo_pkg::item_t item_next;
    logic            accept;

    assign pitch_ready = !valid_reg || push_ready;
    assign accept      = pitch_valid && pitch_ready;

    always_comb
    begin
        item_next.err  = bppo_pkg::ERR_W'(pitch_angle) - bppo_pkg::ERR_W'(pitch_reference);
        item_next.rate = pitch_rate;
        if (accept)
        begin
            // a disabled tick is taken and dropped here
            valid_next = loop_enable;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

>>> hdl/bppo_queue.sv
// Two-word queue between front end and datapath.
// Depends on bppo_pkg.

module bppo_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  bppo_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output bppo_pkg::item_t rd_item
);

    bppo_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

>>> hdl/bppo_back.sv
// Datapath: gain products, integral update with clamp, output clamp and wheel split.
// Depends on bppo_pkg; the stages advance together whenever the output register is free.

module bppo_back
#(
    parameter int INTEGRAL_LIMIT = bppo_pkg::INTEGRAL_LIMIT_DEF,
    parameter int OUTPUT_LIMIT   = bppo_pkg::OUTPUT_LIMIT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_valid,
    output logic                                 rd_ready,
    input  bppo_pkg::item_t                      rd_item,
    input  bppo_pkg::gains_t                     gains,
    input  logic                                 integ_clear,
    output logic                                 wheel_valid,
    input  logic                                 wheel_ready,
    output logic signed [bppo_pkg::WHEEL_W-1:0]  wheel_a_target,
    output logic signed [bppo_pkg::WHEEL_W-1:0]  wheel_b_target
);

    localparam longint ILIM_SCALED = longint'(INTEGRAL_LIMIT) * 256;
    localparam longint OLIM_SCALED = longint'(OUTPUT_LIMIT) * 65536;
    localparam int     ISUM_W      = $clog2(ILIM_SCALED + 1) + 1;
    localparam int     BASE_W      = $clog2(OUTPUT_LIMIT + 1) + 1;

    localparam logic signed [bppo_pkg::SUM_W-1:0] ILIM_S = bppo_pkg::SUM_W'(ILIM_SCALED);
    localparam logic signed [bppo_pkg::U_W-1:0]   OLIM_U = bppo_pkg::U_W'(OLIM_SCALED);
    localparam logic signed [ISUM_W-1:0]          ILIM_I = ISUM_W'(ILIM_SCALED);
    localparam logic signed [BASE_W-1:0]          OLIM_B = BASE_W'(OUTPUT_LIMIT);

    logic adv;

    // stage 1: products
    logic                                      s1_valid_reg;
    logic signed [bppo_pkg::PROD_E_W-1:0]      prop_p_reg, prop_p_next;
    logic signed [bppo_pkg::PROD_E_W-1:0]      integ_p_reg, integ_p_next;
    logic signed [bppo_pkg::PROD_R_W-1:0]      deriv_p_reg, deriv_p_next;

    // stage 2: integral and prop minus deriv
    logic                                      s2_valid_reg;
    logic signed [ISUM_W-1:0]                  integral_reg, integral_next;
    logic signed [bppo_pkg::PD_W-1:0]          pd_reg, pd_next;
    logic        [bppo_pkg::PROD_E_W-1:0]      inc_mag;
    logic        [bppo_pkg::PROD_E_W-1:0]      inc_rnd;
    logic signed [bppo_pkg::SUM_W-1:0]         inc;
    logic signed [bppo_pkg::SUM_W-1:0]         isum;

    // stage 3: controller output, clamped and truncated
    logic                                      s3_valid_reg;
    logic signed [BASE_W-1:0]                  base_reg, base_next;
    logic signed [bppo_pkg::U_W-1:0]           u_sum;
    logic signed [bppo_pkg::U_W-1:0]           u_clamp;
    logic signed [bppo_pkg::U_W-1:0]           u_quot;

    // output register
    logic                                      out_valid_reg;
    logic signed [bppo_pkg::WHEEL_W-1:0]       wa_reg, wa_next;
    logic signed [bppo_pkg::WHEEL_W-1:0]       wb_reg, wb_next;
    logic signed [bppo_pkg::WSUM_W-1:0]        wa_sum;
    logic signed [bppo_pkg::WSUM_W-1:0]        wb_sum;

    assign adv      = !out_valid_reg || wheel_ready;
    assign rd_ready = adv;

    always_comb
    begin
        prop_p_next  = bppo_pkg::PROD_E_W'(gains.prop) * bppo_pkg::PROD_E_W'(rd_item.err);
        integ_p_next = bppo_pkg::PROD_E_W'(gains.integ) * bppo_pkg::PROD_E_W'(rd_item.err);
        deriv_p_next = bppo_pkg::PROD_R_W'(gains.deriv) * bppo_pkg::PROD_R_W'(rd_item.rate);
    end

    // increment rounded to nearest 1/256, ties away from zero
    always_comb
    begin
        inc_mag = integ_p_reg[bppo_pkg::PROD_E_W-1] ? -integ_p_reg : integ_p_reg;
        inc_rnd = inc_mag + bppo_pkg::PROD_E_W'(128);
        inc     = bppo_pkg::SUM_W'(inc_rnd[bppo_pkg::PROD_E_W-1:8]);
        if (integ_p_reg[bppo_pkg::PROD_E_W-1])
        begin
            inc = -inc;
        end
        isum = bppo_pkg::SUM_W'(integral_reg) + inc;
        if (isum > ILIM_S)
        begin
            integral_next = ILIM_I;
        end
        else if (isum < -ILIM_S)
        begin
            integral_next = -ILIM_I;
        end
        else
        begin
            integral_next = ISUM_W'(isum);
        end
        pd_next = bppo_pkg::PD_W'(prop_p_reg) - bppo_pkg::PD_W'(deriv_p_reg);
    end

    // integral_reg already holds this word's updated value when it reaches stage 3
    always_comb
    begin
        u_sum = bppo_pkg::U_W'(pd_reg) + (bppo_pkg::U_W'(integral_reg) <<< 8);
        if (u_sum > OLIM_U)
        begin
            u_clamp = OLIM_U;
        end
        else if (u_sum < -OLIM_U)
        begin
            u_clamp = -OLIM_U;
        end
        else
        begin
            u_clamp = u_sum;
        end
        u_quot = u_clamp >>> 16;
        if (u_clamp[bppo_pkg::U_W-1] && (u_clamp[15:0] != 16'd0))
        begin
            u_quot = u_quot + bppo_pkg::U_W'(1);
        end
        base_next = BASE_W'(u_quot);
    end

    always_comb
    begin
        wa_sum = bppo_pkg::WSUM_W'(base_reg) + bppo_pkg::WSUM_W'(gains.steer);
        wb_sum = bppo_pkg::WSUM_W'(base_reg) - bppo_pkg::WSUM_W'(gains.steer);
        if (wa_sum > bppo_pkg::WHEEL_MAX)
        begin
            wa_next = bppo_pkg::WHEEL_W'(bppo_pkg::WHEEL_MAX);
        end
        else if (wa_sum < bppo_pkg::WHEEL_MIN)
        begin
            wa_next = bppo_pkg::WHEEL_W'(bppo_pkg::WHEEL_MIN);
        end
        else
        begin
            wa_next = wa_sum[bppo_pkg::WHEEL_W-1:0];
        end
        if (wb_sum > bppo_pkg::WHEEL_MAX)
        begin
            wb_next = bppo_pkg::WHEEL_W'(bppo_pkg::WHEEL_MAX);
        end
        else if (wb_sum < bppo_pkg::WHEEL_MIN)
        begin
            wb_next = bppo_pkg::WHEEL_W'(bppo_pkg::WHEEL_MIN);
        end
        else
        begin
            wb_next = wb_sum[bppo_pkg::WHEEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= rd_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (integ_clear)
            begin
                integral_reg <= '0;
            end
            else if (adv && s1_valid_reg)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prop_p_reg  <= prop_p_next;
            integ_p_reg <= integ_p_next;
            deriv_p_reg <= deriv_p_next;
            pd_reg      <= pd_next;
            base_reg    <= base_next;
            wa_reg      <= wa_next;
            wb_reg      <= wb_next;
        end
    end

    assign wheel_valid    = out_valid_reg;
    assign wheel_a_target = wa_reg;
    assign wheel_b_target = wb_reg;

`ifndef NO_ASSERTIONS
    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= ILIM_I) && (integral_reg >= -ILIM_I))
        else $error("integral outside its clamp");

    a_integral_clear: assert property (@(posedge clk) disable iff (!rst_n)
        integ_clear |=> (integral_reg == '0))
        else $error("integral not cleared");

    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> ((base_reg <= OLIM_B) && (base_reg >= -OLIM_B)))
        else $error("base outside output clamp");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv && !integ_clear) |=> $stable(integral_reg))
        else $error("integral moved during stall");
`endif

endmodule

>>> hdl/balance_pitch_pid_outer_loop.sv
// Top level of the pitch-balance PID outer loop: APB register file and the
// front end / queue / datapath chain. Depends on bppo_pkg, bppo_front, bppo_queue, bppo_back.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  pitch    | pitch_valid / pitch_ready  | pitch_angle, pitch_rate
//  wheel    | wheel_valid / wheel_ready  | wheel_a_target, wheel_b_target
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready = 1)
//
// One word per cycle sustained while wheel_ready stays high; a result passes through the
// front register, queue, product stage, integral stage, output clamp stage and output register.
// The integral add-and-clamp is a loop closed on the integral register in the integral stage.
// rst_n clears all valid flags, the queue and the integral; registers return to their
// reset values. A stalled wheel output freezes the datapath; the queue and front register
// keep taking words until they fill. Disabled ticks are taken and produce no result.

module balance_pitch_pid_outer_loop
#(
    parameter int INTEGRAL_LIMIT = bppo_pkg::INTEGRAL_LIMIT_DEF,
    parameter int OUTPUT_LIMIT   = bppo_pkg::OUTPUT_LIMIT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bppo_pkg::ADDR_W-1:0]          paddr,
    input  logic [bppo_pkg::DATA_W-1:0]          pwdata,
    output logic [bppo_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 pitch_valid,
    output logic                                 pitch_ready,
    input  logic signed [bppo_pkg::ANGLE_W-1:0]  pitch_angle,
    input  logic signed [bppo_pkg::RATE_W-1:0]   pitch_rate,
    output logic                                 wheel_valid,
    input  logic                                 wheel_ready,
    output logic signed [bppo_pkg::WHEEL_W-1:0]  wheel_a_target,
    output logic signed [bppo_pkg::WHEEL_W-1:0]  wheel_b_target
);

    logic                                   enable_reg;
    logic signed [bppo_pkg::ANGLE_W-1:0]    ref_reg;
    bppo_pkg::gains_t                       gains_reg;
    logic                                   wr_en;
    logic                                   integ_clear;
    bppo_pkg::reg_idx_t                     idx;

    logic            push_valid;
    logic            push_ready;
    bppo_pkg::item_t push_item;
    logic            rd_valid;
    logic            rd_ready;
    bppo_pkg::item_t rd_item;

    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite && pready;
    assign idx         = bppo_pkg::reg_idx_t'(paddr[bppo_pkg::ADDR_W-1:2]);
    assign integ_clear = wr_en && (idx == bppo_pkg::REG_ENABLE) && !pwdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            ref_reg         <= '0;
            gains_reg.prop  <= bppo_pkg::GAIN_PROP_RST;
            gains_reg.integ <= '0;
            gains_reg.deriv <= '0;
            gains_reg.steer <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                bppo_pkg::REG_ENABLE: enable_reg      <= pwdata[0];
                bppo_pkg::REG_REF:    ref_reg         <= pwdata[bppo_pkg::ANGLE_W-1:0];
                bppo_pkg::REG_KP:     gains_reg.prop  <= pwdata[bppo_pkg::GAIN_W-1:0];
                bppo_pkg::REG_KI:     gains_reg.integ <= pwdata[bppo_pkg::GAIN_W-1:0];
                bppo_pkg::REG_KD:     gains_reg.deriv <= pwdata[bppo_pkg::GAIN_W-1:0];
                bppo_pkg::REG_STEER:  gains_reg.steer <= pwdata[bppo_pkg::STEER_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bppo_pkg::REG_ENABLE: prdata = bppo_pkg::DATA_W'(enable_reg);
            bppo_pkg::REG_REF:    prdata = bppo_pkg::DATA_W'(ref_reg);
            bppo_pkg::REG_KP:     prdata = bppo_pkg::DATA_W'(gains_reg.prop);
            bppo_pkg::REG_KI:     prdata = bppo_pkg::DATA_W'(gains_reg.integ);
            bppo_pkg::REG_KD:     prdata = bppo_pkg::DATA_W'(gains_reg.deriv);
            bppo_pkg::REG_STEER:  prdata = bppo_pkg::DATA_W'(gains_reg.steer);
            default:              prdata = '0;
        endcase
    end

    bppo_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .pitch_valid     (pitch_valid),
        .pitch_ready     (pitch_ready),
        .pitch_angle     (pitch_angle),
        .pitch_rate      (pitch_rate),
        .loop_enable     (enable_reg),
        .pitch_reference (ref_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_item       (push_item)
    );

    bppo_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_item  (rd_item)
    );

    bppo_back
    #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .OUTPUT_LIMIT   (OUTPUT_LIMIT)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd_valid       (rd_valid),
        .rd_ready       (rd_ready),
        .rd_item        (rd_item),
        .gains          (gains_reg),
        .integ_clear    (integ_clear),
        .wheel_valid    (wheel_valid),
        .wheel_ready    (wheel_ready),
        .wheel_a_target (wheel_a_target),
        .wheel_b_target (wheel_b_target)
    );

endmodule

>>> tb/balance_pitch_pid_outer_loop_test.sv
`timescale 1ns / 1ps
// Self-checking bench for balance_pitch_pid_outer_loop: pitch words in, wheel words checked
// against a local PID predictor. Depends on bppo_pkg and the RTL in hdl/.

module balance_pitch_pid_outer_loop_test;

    localparam int INTEG_LIM     = bppo_pkg::INTEGRAL_LIMIT_DEF;
    localparam int OUT_LIM       = bppo_pkg::OUTPUT_LIMIT_DEF;
    localparam int UNUSED_REG_LO = 6;
    localparam int UNUSED_REG_HI = 7;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 120;

    typedef enum {RX_ALWAYS, RX_MOSTLY, RX_RARE, RX_ALTERNATE} rx_mode_t;

    typedef struct packed {
        logic signed [bppo_pkg::WHEEL_W-1:0] a;
        logic signed [bppo_pkg::WHEEL_W-1:0] b;
    } wheel_pair_t;

    logic                                  clk;
    logic                                  rst_n = 1'b0;
    logic                                  psel = 1'b0;
    logic                                  penable = 1'b0;
    logic                                  pwrite = 1'b0;
    logic [bppo_pkg::ADDR_W-1:0]           paddr = '0;
    logic [bppo_pkg::DATA_W-1:0]           pwdata = '0;
    logic [bppo_pkg::DATA_W-1:0]           prdata;
    logic                                  pready;
    logic                                  pitch_valid = 1'b0;
    logic                                  pitch_ready;
    logic signed [bppo_pkg::ANGLE_W-1:0]   pitch_angle = '0;
    logic signed [bppo_pkg::RATE_W-1:0]    pitch_rate = '0;
    logic                                  wheel_valid;
    logic                                  wheel_ready = 1'b0;
    logic signed [bppo_pkg::WHEEL_W-1:0]   wheel_a_target;
    logic signed [bppo_pkg::WHEEL_W-1:0]   wheel_b_target;

    // predictor copy of the register file and integral
    logic                                  cfg_enable;
    logic signed [bppo_pkg::ANGLE_W-1:0]   cfg_ref;
    logic signed [bppo_pkg::GAIN_W-1:0]    cfg_kp;
    logic signed [bppo_pkg::GAIN_W-1:0]    cfg_ki;
    logic signed [bppo_pkg::GAIN_W-1:0]    cfg_kd;
    logic signed [bppo_pkg::STEER_W-1:0]   cfg_steer;
    longint                                integ_sum;

    wheel_pair_t                 wheel_expected[$];
    wheel_pair_t                 wheel_want;
    int                          fault_count = 0;
    int                          burst_left = 0;
    int                          rx_hold = 0;
    int                          rx_mode_left = 0;
    rx_mode_t                    rx_mode = RX_ALWAYS;

    balance_pitch_pid_outer_loop
    #(
        .INTEGRAL_LIMIT (INTEG_LIM),
        .OUTPUT_LIMIT   (OUT_LIM)
    )
    DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pitch_valid    (pitch_valid),
        .pitch_ready    (pitch_ready),
        .pitch_angle    (pitch_angle),
        .pitch_rate     (pitch_rate),
        .wheel_valid    (wheel_valid),
        .wheel_ready    (wheel_ready),
        .wheel_a_target (wheel_a_target),
        .wheel_b_target (wheel_b_target)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    function automatic logic signed [bppo_pkg::WHEEL_W-1:0] sat_wheel(longint x);
        longint top;
        top = (longint'(1) <<< (bppo_pkg::WHEEL_W - 1)) - 1;
        if (x > top)
            x = top;
        else if (x < -top - 1)
            x = -top - 1;
        return bppo_pkg::WHEEL_W'(x);
    endfunction

    // integral update and wheel targets for one accepted pitch word
    function automatic void predict_wheels(logic signed [bppo_pkg::ANGLE_W-1:0] angle,
                                           logic signed [bppo_pkg::RATE_W-1:0] rate);
        longint      err;
        longint      prod;
        longint      inc;
        longint      u;
        longint      base;
        wheel_pair_t w;
        if (!cfg_enable)
        begin
            integ_sum = 0;
            return;
        end
        err  = longint'(angle) - longint'(cfg_ref);
        prod = longint'(cfg_ki) * err;
        // half away from zero
        if (prod >= 0)
            inc = (prod + 128) / 256;
        else
            inc = -((-prod + 128) / 256);
        integ_sum = clamp_sym(integ_sum + inc, longint'(INTEG_LIM) * 256);
        u = longint'(cfg_kp) * err + integ_sum * 256 - longint'(cfg_kd) * longint'(rate);
        u = clamp_sym(u, longint'(OUT_LIM) * 65536);
        base = u / 65536;
        w.a = sat_wheel(base + longint'(cfg_steer));
        w.b = sat_wheel(base - longint'(cfg_steer));
        wheel_expected.push_back(w);
    endfunction

    function automatic void apply_register(int idx, logic [bppo_pkg::DATA_W-1:0] value);
        case (idx)
            bppo_pkg::REG_ENABLE:
            begin
                cfg_enable = value[0];
                if (!value[0])
                    integ_sum = 0;
            end
            bppo_pkg::REG_REF:   cfg_ref   = value[bppo_pkg::ANGLE_W-1:0];
            bppo_pkg::REG_KP:    cfg_kp    = value[bppo_pkg::GAIN_W-1:0];
            bppo_pkg::REG_KI:    cfg_ki    = value[bppo_pkg::GAIN_W-1:0];
            bppo_pkg::REG_KD:    cfg_kd    = value[bppo_pkg::GAIN_W-1:0];
            bppo_pkg::REG_STEER: cfg_steer = value[bppo_pkg::STEER_W-1:0];
            default:   ;
        endcase
    endfunction

    task automatic note_fault(string text);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%s", text);
    endtask

    // wheel word checker
    always @(posedge clk)
    begin
        if (rst_n && wheel_valid && wheel_ready)
        begin
            if (wheel_expected.size() == 0)
                note_fault($sformatf("%0t: unexpected wheel word a=%0d b=%0d",
                                     $time, wheel_a_target, wheel_b_target));
            else
            begin
                wheel_want = wheel_expected.pop_front();
                if (wheel_a_target !== wheel_want.a || wheel_b_target !== wheel_want.b)
                    note_fault($sformatf("%0t: wheel mismatch a exp %0d got %0d, b exp %0d got %0d",
                                         $time, wheel_want.a, wheel_a_target,
                                         wheel_want.b, wheel_b_target));
            end
        end
    end

    // receiver: stall pattern changes every so often; rx_hold forces a long hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            wheel_ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS:    wheel_ready <= 1'b1;
                RX_MOSTLY:    wheel_ready <= ($urandom_range(0, 3) != 0);
                RX_RARE:      wheel_ready <= ($urandom_range(0, 3) == 0);
                RX_ALTERNATE: wheel_ready <= ~wheel_ready;
                default:      wheel_ready <= 1'b1;
            endcase
        end
    end

    task automatic send_tick(logic signed [bppo_pkg::ANGLE_W-1:0] angle,
                             logic signed [bppo_pkg::RATE_W-1:0] rate);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 30);
            endcase
        end
        if (gap > 0)
        begin
            @(negedge clk);
            pitch_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pitch_valid <= 1'b1;
        pitch_angle <= angle;
        pitch_rate  <= rate;
        do @(posedge clk); while (!pitch_ready);
        predict_wheels(angle, rate);
        burst_left--;
    endtask

    // drop valid, wait for every expected word, then let disabled ticks drain
    task automatic settle();
        @(negedge clk);
        pitch_valid <= 1'b0;
        burst_left = 0;
        while (wheel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(int idx, logic [bppo_pkg::DATA_W-1:0] value);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bppo_pkg::ADDR_W'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apply_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic pick_tick(output logic signed [bppo_pkg::ANGLE_W-1:0] angle,
                             output logic signed [bppo_pkg::RATE_W-1:0] rate);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                // small error around the reference
                angle = cfg_ref + bppo_pkg::ANGLE_W'(int'($urandom_range(0, 1600)) - 800);
                rate  = bppo_pkg::RATE_W'(int'($urandom_range(0, 4000)) - 2000);
            end
            5, 6, 7:
            begin
                angle = bppo_pkg::ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
                rate  = bppo_pkg::RATE_W'($urandom());
            end
            default:
            begin
                angle = bppo_pkg::ANGLE_W'($urandom());
                rate  = bppo_pkg::RATE_W'($urandom());
            end
        endcase
    endtask

    task automatic test_disabled_ticks();
        repeat (6) send_tick(bppo_pkg::ANGLE_W'($urandom()), bppo_pkg::RATE_W'($urandom()));
        settle();
    endtask

    task automatic test_directed();
        cfg_write(bppo_pkg::REG_ENABLE, 1);
        send_tick(0, 0);
        send_tick(46080, 0);
        send_tick(-46080, 0);
        send_tick(17'h0FFFF, 20'h7FFFF);
        send_tick(17'h10000, 20'h80000);
        send_tick(1, 0);
        // truncation toward zero: -64512/65536 gives 0, -66048/65536 gives -1
        send_tick(-42, 0);
        send_tick(-43, 0);
        cfg_write(bppo_pkg::REG_KD, 256);
        cfg_write(bppo_pkg::REG_STEER, 1000);
        send_tick(0, 12800);
        send_tick(0, -12800);
        cfg_write(bppo_pkg::REG_STEER, -1000);
        send_tick(100, 524287);
        // integral rounding ties
        cfg_write(bppo_pkg::REG_KP, 0);
        cfg_write(bppo_pkg::REG_KD, 0);
        cfg_write(bppo_pkg::REG_STEER, 0);
        cfg_write(bppo_pkg::REG_KI, 1);
        send_tick(128, 0);
        send_tick(-128, 0);
        send_tick(127, 0);
        send_tick(-127, 0);
        send_tick(384, 0);
        // integral clamp both ways
        cfg_write(bppo_pkg::REG_KI, 32767);
        send_tick(46080, 0);
        send_tick(46080, 0);
        send_tick(-46080, 0);
        send_tick(-46080, 0);
        cfg_write(bppo_pkg::REG_KI, 0);
        send_tick(0, 0);
        // only bit 0 of the enable counts; disabling clears the integral
        cfg_write(bppo_pkg::REG_ENABLE, 32'hFFFF_FFFE);
        send_tick(5000, 1000);
        cfg_write(bppo_pkg::REG_ENABLE, 1);
        send_tick(0, 0);
        // writes to unmapped addresses must not disturb anything
        cfg_write(bppo_pkg::REG_KP, 32'(bppo_pkg::GAIN_PROP_RST));
        cfg_write(UNUSED_REG_LO, 32'hFFFF_FFFF);
        cfg_write(UNUSED_REG_HI, 32'hFFFF_FFFF);
        send_tick(256, 0);
        settle();
    endtask

    task automatic choose_settings(int style);
        logic [bppo_pkg::DATA_W-1:0] kp;
        logic [bppo_pkg::DATA_W-1:0] ki;
        logic [bppo_pkg::DATA_W-1:0] kd;
        logic [bppo_pkg::DATA_W-1:0] rf;
        logic [bppo_pkg::DATA_W-1:0] st;
        case (style)
            0:
            begin
                kp = $urandom_range(0, 3072);
                ki = int'($urandom_range(0, 64)) - 32;
                kd = int'($urandom_range(0, 1024)) - 512;
                rf = int'($urandom_range(0, 4000)) - 2000;
                st = int'($urandom_range(0, 2000)) - 1000;
            end
            1:
            begin
                kp = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
                ki = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
                kd = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
                case ($urandom_range(0, 3))
                    0:       rf = 46080;
                    1:       rf = -46080;
                    2:       rf = 32'h0000_FFFF;
                    default: rf = 32'h0001_0000;
                endcase
                case ($urandom_range(0, 3))
                    0:       st = 1000;
                    1:       st = -1000;
                    2:       st = 1023;
                    default: st = -1024;
                endcase
            end
            default:
            begin
                kp = $urandom();
                ki = $urandom();
                kd = $urandom();
                rf = $urandom();
                st = $urandom();
            end
        endcase
        if ($urandom_range(0, 1))
            cfg_write(bppo_pkg::REG_ENABLE, 0);
        cfg_write(bppo_pkg::REG_ENABLE, 1);
        cfg_write(bppo_pkg::REG_REF, rf);
        cfg_write(bppo_pkg::REG_KP, kp);
        cfg_write(bppo_pkg::REG_KI, ki);
        cfg_write(bppo_pkg::REG_KD, kd);
        cfg_write(bppo_pkg::REG_STEER, st);
    endtask

    task automatic test_random_settings();
        logic signed [bppo_pkg::ANGLE_W-1:0] angle;
        logic signed [bppo_pkg::RATE_W-1:0]  rate;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            choose_settings(p % 3);
            repeat (PHASE_TICKS)
            begin
                pick_tick(angle, rate);
                send_tick(angle, rate);
            end
        end
        settle();
    endtask

    // long receiver hold-off while words keep coming, then a full drain
    task automatic test_backpressure();
        logic signed [bppo_pkg::ANGLE_W-1:0] angle;
        logic signed [bppo_pkg::RATE_W-1:0]  rate;
        choose_settings(0);
        rx_hold = 400;
        repeat (130)
        begin
            pick_tick(angle, rate);
            send_tick(angle, rate);
        end
        settle();
    endtask

    initial
    begin
        cfg_enable = 1'b0;
        cfg_ref    = '0;
        cfg_kp     = bppo_pkg::GAIN_PROP_RST;
        cfg_ki     = '0;
        cfg_kd     = '0;
        cfg_steer  = '0;
        integ_sum  = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_disabled_ticks();
        test_directed();
        test_random_settings();
        test_backpressure();
        settle();

        if (wheel_expected.size() != 0)
            note_fault($sformatf("%0d wheel words never arrived", wheel_expected.size()));
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
